### hw/rtl/prrq_pkg.sv
// Shared types, constants and codes of the priority round-robin ready queue.
`default_nettype none
package prrq_pkg;

   localparam int THREAD_SLOTS_DEF    = 64;
   localparam int PRIORITY_LEVELS_DEF = 256;
   localparam int CSR_IDX_W           = 2;
   localparam int CSR_DATA_W          = 15;
   localparam int SEARCH_WIDTH        = 8;
   localparam logic [14:0] TIMESLICE_RST = 15'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IDLE_THREAD = 2'd0,
      CSR_IDLE_PRIO   = 2'd1,
      CSR_TIMESLICE   = 2'd2
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_INIT      = 4'd0,
      OP_ENQUEUE   = 4'd1,
      OP_DEQUEUE   = 4'd2,
      OP_TICK      = 4'd3,
      OP_ROTATE    = 4'd4,
      OP_SET_OWNER = 4'd5,
      OP_SAVE      = 4'd6,
      OP_EXHAUST   = 4'd7,
      OP_SET_TICKS = 4'd8
   } op_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic [5:0]         thread;
      logic [7:0]         priority_req;
      logic signed [15:0] ticks;
   } req_type;

   typedef struct packed {
      logic [5:0]         next_thread;
      logic [7:0]         highest_priority;
      logic [5:0]         owner_thread;
      logic signed [15:0] ticks_remaining;
      logic               expired;
      logic               error;
   } rsp_type;

   // controller to datapath, one strobe per step
   typedef struct packed {
      logic ld_req;
      logic init;
      logic enq_meta;
      logic srch;
      logic enq_fol;
      logic enq_bwd;
      logic enq_lnk1;
      logic enq_lnk2;
      logic enq_self;
      logic deq_rd0;
      logic deq_rd1;
      logic deq_rd2;
      logic deq_cmt;
      logic tick;
      logic rot_rd0;
      logic rot_rd1;
      logic rot_wr;
      logic own_rd;
      logic own_ld;
      logic sav_rd;
      logic sav_wr;
      logic exhaust;
      logic set_ticks;
      logic flag_err;
      logic rsp_rd;
      logic rsp_go;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   queued_t;
      logic   rot_ok;
      logic   srch_hit;
      logic   srch_end;
      logic   was_occ;
   } stat_type;

endpackage
`default_nettype wire

### hw/rtl/priority_round_robin_ready_queue.sv
// Top level of the priority round-robin ready queue.
//
//   channel | ports                                  | handshake
//   request | start, busy, req_data                  | taken when start && !busy
//   result  | rsp_valid, rsp_data                    | one-cycle strobe, no stall
//   config  | csr_valid, csr_ready, csr_index, csr_data | write when valid && ready
//
// One request at a time: busy rises the cycle after acceptance and falls as the
// result strobes. Tick, exhaust, set ticks, init, unused codes, rotate with nothing
// to do and rejected enqueue or dequeue go straight to the result; set owner adds a
// load, save a write-back, rotate a read and write, dequeue reads and a commit,
// enqueue the occupancy-map search and links (a self-link if empty). RAM reads
// are registered. Synchronous reset clears occupancy, queued bits, top level,
// count and owner; the tables hold no reset value. Results cannot be stalled.
`default_nettype none
module priority_round_robin_ready_queue
   import prrq_pkg::*;
#(
   parameter int THREAD_SLOTS    = THREAD_SLOTS_DEF,
   parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);
   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   prrq_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .stat, .cmd);

   prrq_dp #(
      .THREAD_SLOTS(THREAD_SLOTS),
      .PRIORITY_LEVELS(PRIORITY_LEVELS)
   ) u_dp (
      .clock, .reset, .req_data, .cmd, .stat,
      .csr_valid, .csr_index, .csr_data,
      .rsp_valid, .rsp_data);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted request did not raise busy");
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while a request is in progress");
endmodule
`default_nettype wire

### hw/rtl/prrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module prrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

### hw/rtl/prrq_ctrl.sv
// Sequencer of the ready queue: steps each request through its table accesses.
`default_nettype none
module prrq_ctrl
   import prrq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   typedef enum logic [16:0] {
      S_IDLE     = 17'h00001,
      S_DECODE   = 17'h00002,
      S_SRCH     = 17'h00004,
      S_ENQ_FOL  = 17'h00008,
      S_ENQ_BWD  = 17'h00010,
      S_ENQ_LNK1 = 17'h00020,
      S_ENQ_LNK2 = 17'h00040,
      S_ENQ_SELF = 17'h00080,
      S_DEQ_RD1  = 17'h00100,
      S_DEQ_RD2  = 17'h00200,
      S_DEQ_CMT  = 17'h00400,
      S_ROT_RD1  = 17'h00800,
      S_ROT_WR   = 17'h01000,
      S_OWN_LD   = 17'h02000,
      S_SAV_WR   = 17'h04000,
      S_RSP_RD   = 17'h08000,
      S_RSP_GO   = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.ld_req = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RSP_RD;
            case (stat.op)
               OP_INIT: cmd.init = 1'b1;
               OP_ENQUEUE: begin
                  if (stat.queued_t) cmd.flag_err = 1'b1;
                  else begin
                     cmd.enq_meta = 1'b1;
                     state_in     = S_SRCH;
                  end
               end
               OP_DEQUEUE: begin
                  if (!stat.queued_t) cmd.flag_err = 1'b1;
                  else begin
                     cmd.deq_rd0 = 1'b1;
                     state_in    = S_DEQ_RD1;
                  end
               end
               OP_TICK: cmd.tick = 1'b1;
               OP_ROTATE: begin
                  if (stat.rot_ok) begin
                     cmd.rot_rd0 = 1'b1;
                     state_in    = S_ROT_RD1;
                  end
               end
               OP_SET_OWNER: begin
                  cmd.own_rd = 1'b1;
                  state_in   = S_OWN_LD;
               end
               OP_SAVE: begin
                  cmd.sav_rd = 1'b1;
                  state_in   = S_SAV_WR;
               end
               OP_EXHAUST:   cmd.exhaust   = 1'b1;
               OP_SET_TICKS: cmd.set_ticks = 1'b1;
               default: ;
            endcase
         end
         S_SRCH: begin
            cmd.srch = 1'b1;
            if (stat.srch_hit || (stat.srch_end && stat.was_occ)) state_in = S_ENQ_FOL;
            else if (stat.srch_end) state_in = S_ENQ_SELF;
         end
         S_ENQ_FOL: begin
            cmd.enq_fol = 1'b1;
            state_in    = S_ENQ_BWD;
         end
         S_ENQ_BWD: begin
            cmd.enq_bwd = 1'b1;
            state_in    = S_ENQ_LNK1;
         end
         S_ENQ_LNK1: begin
            cmd.enq_lnk1 = 1'b1;
            state_in     = S_ENQ_LNK2;
         end
         S_ENQ_LNK2: begin
            cmd.enq_lnk2 = 1'b1;
            state_in     = S_RSP_RD;
         end
         S_ENQ_SELF: begin
            cmd.enq_self = 1'b1;
            state_in     = S_RSP_RD;
         end
         S_DEQ_RD1: begin
            cmd.deq_rd1 = 1'b1;
            state_in    = S_DEQ_RD2;
         end
         S_DEQ_RD2: begin
            cmd.deq_rd2 = 1'b1;
            state_in    = S_DEQ_CMT;
         end
         S_DEQ_CMT: begin
            cmd.deq_cmt = 1'b1;
            state_in    = S_RSP_RD;
         end
         S_ROT_RD1: begin
            cmd.rot_rd1 = 1'b1;
            state_in    = S_ROT_WR;
         end
         S_ROT_WR: begin
            cmd.rot_wr = 1'b1;
            state_in   = S_RSP_RD;
         end
         S_OWN_LD: begin
            cmd.own_ld = 1'b1;
            state_in   = S_RSP_RD;
         end
         S_SAV_WR: begin
            cmd.sav_wr = 1'b1;
            state_in   = S_RSP_RD;
         end
         S_RSP_RD: begin
            cmd.rsp_rd = 1'b1;
            state_in   = S_RSP_GO;
         end
         S_RSP_GO: begin
            cmd.rsp_go = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

### hw/rtl/prrq_dp.sv
// Datapath of the ready queue: tables, occupancy map, level search, slice counter.
`default_nettype none
module prrq_dp
   import prrq_pkg::*;
#(
   parameter int THREAD_SLOTS    = THREAD_SLOTS_DEF,
   parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data
);
   localparam int TW = $clog2(THREAD_SLOTS);
   localparam int LW = $clog2(PRIORITY_LEVELS);
   localparam int SW = (PRIORITY_LEVELS < SEARCH_WIDTH) ? PRIORITY_LEVELS : SEARCH_WIDTH;
   localparam int RW = LW + 1;

   // configuration
   logic [5:0]  idle_thread_ff;
   logic [7:0]  idle_prio_ff;
   logic [14:0] timeslice_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_thread_ff <= '0;
         idle_prio_ff   <= '0;
         timeslice_ff   <= TIMESLICE_RST;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_IDLE_THREAD: idle_thread_ff <= csr_data[5:0];
            CSR_IDLE_PRIO:   idle_prio_ff   <= csr_data[7:0];
            CSR_TIMESLICE:   timeslice_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // latched request, ids saturated to the table sizes
   op_type             op_ff;
   logic [TW-1:0]      rq_t_ff;
   logic [LW-1:0]      rq_p_ff;
   logic signed [15:0] rq_tk_ff;
   logic [31:0]        req_t32, req_p32, idle_t32, idle_p32;
   logic [TW-1:0]      idle_t;
   logic [LW-1:0]      idle_p;

   assign req_t32  = 32'(req_data.thread);
   assign req_p32  = 32'(req_data.priority_req);
   assign idle_t32 = 32'(idle_thread_ff);
   assign idle_p32 = 32'(idle_prio_ff);
   assign idle_t   = (idle_t32 < 32'(THREAD_SLOTS)) ? idle_t32[TW-1:0] : TW'(THREAD_SLOTS - 1);
   assign idle_p   = (idle_p32 < 32'(PRIORITY_LEVELS)) ? idle_p32[LW-1:0]
                                                        : LW'(PRIORITY_LEVELS - 1);

   always_ff @(posedge clock) begin
      if (cmd.ld_req) begin
         op_ff    <= op_type'(req_data.operation);
         rq_t_ff  <= (req_t32 < 32'(THREAD_SLOTS)) ? req_t32[TW-1:0] : TW'(THREAD_SLOTS - 1);
         rq_p_ff  <= (req_p32 < 32'(PRIORITY_LEVELS)) ? req_p32[LW-1:0]
                                                       : LW'(PRIORITY_LEVELS - 1);
         rq_tk_ff <= req_data.ticks;
      end
   end

   // table RAMs
   logic          fol_we, nol_we, lfw_we, lbw_we, tlv_we, tqu_we, tsv_we;
   logic          fol_re, nol_re, lfw_re, lbw_re, tlv_re, tqu_re, tsv_re;
   logic [LW-1:0] fol_wa, nol_wa, fol_ra, nol_ra;
   logic [TW-1:0] fol_wd, nol_wd, fol_rd, nol_rd;
   logic [TW-1:0] lfw_wa, lbw_wa, lfw_ra, lbw_ra, tlv_wa, tlv_ra, tqu_wa, tsv_wa;
   logic [TW-1:0] lfw_wd, lbw_wd, lfw_rd, lbw_rd, tsv_ra, tqu_ra;
   logic [LW-1:0] tlv_wd, tlv_rd;
   logic [15:0]   tqu_wd, tqu_rd, tsv_wd, tsv_rd;

   prrq_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_fol (
      .clock, .we(fol_we), .waddr(fol_wa), .wdata(fol_wd),
      .re(fol_re), .raddr(fol_ra), .rdata_ff(fol_rd));
   prrq_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_nol (
      .clock, .we(nol_we), .waddr(nol_wa), .wdata(nol_wd),
      .re(nol_re), .raddr(nol_ra), .rdata_ff(nol_rd));
   prrq_ram #(.WIDTH(TW), .DEPTH(THREAD_SLOTS)) u_lfw (
      .clock, .we(lfw_we), .waddr(lfw_wa), .wdata(lfw_wd),
      .re(lfw_re), .raddr(lfw_ra), .rdata_ff(lfw_rd));
   prrq_ram #(.WIDTH(TW), .DEPTH(THREAD_SLOTS)) u_lbw (
      .clock, .we(lbw_we), .waddr(lbw_wa), .wdata(lbw_wd),
      .re(lbw_re), .raddr(lbw_ra), .rdata_ff(lbw_rd));
   prrq_ram #(.WIDTH(LW), .DEPTH(THREAD_SLOTS)) u_tlv (
      .clock, .we(tlv_we), .waddr(tlv_wa), .wdata(tlv_wd),
      .re(tlv_re), .raddr(tlv_ra), .rdata_ff(tlv_rd));
   prrq_ram #(.WIDTH(16), .DEPTH(THREAD_SLOTS)) u_tqu (
      .clock, .we(tqu_we), .waddr(tqu_wa), .wdata(tqu_wd),
      .re(tqu_re), .raddr(tqu_ra), .rdata_ff(tqu_rd));
   prrq_ram #(.WIDTH(16), .DEPTH(THREAD_SLOTS)) u_tsv (
      .clock, .we(tsv_we), .waddr(tsv_wa), .wdata(tsv_wd),
      .re(tsv_re), .raddr(tsv_ra), .rdata_ff(tsv_rd));

   // state
   logic [PRIORITY_LEVELS-1:0] occ_ff, occ_in;
   logic [THREAD_SLOTS-1:0]    queued_ff, queued_in;
   logic [LW-1:0]              top_ff, top_in;
   logic signed [15:0]         count_ff, count_in;
   logic [TW-1:0]              owner_ff, owner_in;
   logic                       err_ff, err_in, exp_ff, exp_in;
   logic                       rsp_valid_ff;

   // work registers
   logic [LW-1:0] lv_ff, lvl_nxt_ff, sib_lvl_ff, srch_ff;
   logic [TW-1:0] nxt_ff, prv_ff, sib_ff, first_ff, next_ff;
   logic [RW-1:0] rem_ff;
   logic          was_occ_ff;

   // windowed search for the next occupied level above the base, with wrap
   logic          hit;
   logic [LW-1:0] hit_lvl;
   logic [LW-1:0] srch_next;
   int            cand, nb;

   always_comb begin
      hit     = 1'b0;
      hit_lvl = '0;
      for (int j = SW - 1; j >= 0; j--) begin
         cand = int'(srch_ff) + 1 + j;
         if (cand >= PRIORITY_LEVELS) cand = cand - PRIORITY_LEVELS;
         if (cand >= PRIORITY_LEVELS) cand = 0;
         if ((RW'(j) < rem_ff) && occ_ff[cand[LW-1:0]]) begin
            hit     = 1'b1;
            hit_lvl = cand[LW-1:0];
         end
      end
      nb = int'(srch_ff) + SW;
      if (nb >= PRIORITY_LEVELS) nb = nb - PRIORITY_LEVELS;
      if (nb >= PRIORITY_LEVELS) nb = 0;
      srch_next = nb[LW-1:0];
   end

   assign stat.op       = op_ff;
   assign stat.queued_t = queued_ff[rq_t_ff];
   assign stat.rot_ok   = (count_ff == 16'sd0) && queued_ff[owner_ff];
   assign stat.srch_hit = hit;
   assign stat.srch_end = (rem_ff <= RW'(SW));
   assign stat.was_occ  = was_occ_ff;

   always_ff @(posedge clock) begin
      if (cmd.enq_meta) begin
         was_occ_ff <= occ_ff[rq_p_ff];
         srch_ff    <= rq_p_ff;
         rem_ff     <= RW'(PRIORITY_LEVELS - 1);
      end
      if (cmd.srch) begin
         srch_ff <= srch_next;
         rem_ff  <= rem_ff - RW'(SW);
         sib_lvl_ff <= hit ? hit_lvl : rq_p_ff;
      end
      if (cmd.enq_bwd) sib_ff <= fol_rd;
      if (cmd.deq_rd1 || cmd.rot_rd1) begin
         lv_ff  <= tlv_rd;
         nxt_ff <= lfw_rd;
      end
      if (cmd.deq_rd1) prv_ff <= lbw_rd;
      if (cmd.deq_rd2) begin
         lvl_nxt_ff <= tlv_rd;
         first_ff   <= fol_rd;
         next_ff    <= nol_rd;
      end
   end

   // dequeue decision
   logic          same, occ_p, occ_new;
   logic [TW-1:0] first_new;
   assign same  = (nxt_ff != rq_t_ff) && (lvl_nxt_ff == lv_ff);
   assign occ_p = occ_ff[lv_ff];

   always_comb begin
      occ_new   = occ_p;
      first_new = first_ff;
      if (occ_p && first_ff == rq_t_ff) begin
         if (same) first_new = nxt_ff;
         else      occ_new   = 1'b0;
      end
   end

   always_comb begin
      fol_we = 1'b0; fol_wa = rq_p_ff; fol_wd = rq_t_ff;
      nol_we = 1'b0; nol_wa = rq_p_ff; nol_wd = rq_t_ff;
      lfw_we = 1'b0; lfw_wa = rq_t_ff; lfw_wd = rq_t_ff;
      lbw_we = 1'b0; lbw_wa = rq_t_ff; lbw_wd = rq_t_ff;
      tlv_we = 1'b0; tlv_wa = rq_t_ff; tlv_wd = rq_p_ff;
      tqu_we = 1'b0; tqu_wa = rq_t_ff; tqu_wd = rq_tk_ff;
      tsv_we = 1'b0; tsv_wa = owner_ff;
      tsv_wd = (count_ff != 16'sd0) ? count_ff : tqu_rd;
      fol_re = 1'b0; fol_ra = sib_lvl_ff;
      nol_re = 1'b0; nol_ra = top_ff;
      lfw_re = 1'b0; lfw_ra = rq_t_ff;
      lbw_re = 1'b0; lbw_ra = rq_t_ff;
      tlv_re = 1'b0; tlv_ra = rq_t_ff;
      tqu_re = 1'b0; tqu_ra = owner_ff;
      tsv_re = 1'b0; tsv_ra = rq_t_ff;
      occ_in    = occ_ff;
      queued_in = queued_ff;
      top_in    = top_ff;
      count_in  = count_ff;
      owner_in  = owner_ff;
      err_in    = err_ff;
      exp_in    = exp_ff;

      if (cmd.ld_req) begin
         err_in = 1'b0;
         exp_in = 1'b0;
      end
      if (cmd.flag_err) err_in = 1'b1;

      if (cmd.init) begin
         fol_we = 1'b1; fol_wa = idle_p; fol_wd = idle_t;
         nol_we = 1'b1; nol_wa = idle_p; nol_wd = idle_t;
         lfw_we = 1'b1; lfw_wa = idle_t; lfw_wd = idle_t;
         lbw_we = 1'b1; lbw_wa = idle_t; lbw_wd = idle_t;
         tlv_we = 1'b1; tlv_wa = idle_t; tlv_wd = idle_p;
         occ_in            = '0;
         occ_in[idle_p]    = 1'b1;
         queued_in         = '0;
         queued_in[idle_t] = 1'b1;
         top_in   = idle_p;
         count_in = 16'(timeslice_ff);
         owner_in = idle_t;
      end

      if (cmd.enq_meta) begin
         tlv_we = 1'b1;
         tqu_we = 1'b1;
      end
      if (cmd.enq_fol) fol_re = 1'b1;
      if (cmd.enq_bwd) begin
         lbw_re = 1'b1;
         lbw_ra = fol_rd;
      end
      if (cmd.enq_lnk1) begin
         lfw_we = 1'b1; lfw_wa = lbw_rd; lfw_wd = rq_t_ff;
         lbw_we = 1'b1; lbw_wa = rq_t_ff; lbw_wd = lbw_rd;
      end
      if (cmd.enq_lnk2) begin
         lfw_we = 1'b1; lfw_wa = rq_t_ff; lfw_wd = sib_ff;
         lbw_we = 1'b1; lbw_wa = sib_ff;  lbw_wd = rq_t_ff;
      end
      if (cmd.enq_self) begin
         lfw_we = 1'b1;
         lbw_we = 1'b1;
      end
      if (cmd.enq_lnk2 || cmd.enq_self) begin
         if (!was_occ_ff) begin
            fol_we = 1'b1;
            nol_we = 1'b1;
         end
         occ_in[rq_p_ff]    = 1'b1;
         queued_in[rq_t_ff] = 1'b1;
         // top level compared against the map with this level now set
         if (rq_p_ff > top_ff || !(occ_ff[top_ff] || top_ff == rq_p_ff)) top_in = rq_p_ff;
      end

      if (cmd.deq_rd0) begin
         tlv_re = 1'b1;
         lfw_re = 1'b1;
         lbw_re = 1'b1;
      end
      if (cmd.deq_rd1) begin
         tlv_re = 1'b1; tlv_ra = lfw_rd;
         fol_re = 1'b1; fol_ra = tlv_rd;
         nol_re = 1'b1; nol_ra = tlv_rd;
      end
      if (cmd.deq_rd2) begin
         tlv_re = 1'b1;
         tlv_ra = prv_ff;
      end
      if (cmd.deq_cmt) begin
         fol_we = occ_p && (first_ff == rq_t_ff) && same;
         fol_wa = lv_ff;
         fol_wd = nxt_ff;
         nol_we = occ_new && (next_ff == rq_t_ff);
         nol_wa = lv_ff;
         nol_wd = same ? nxt_ff : first_new;
         occ_in[lv_ff] = occ_new;
         if (!occ_new && lv_ff == top_ff) top_in = (prv_ff != rq_t_ff) ? tlv_rd : lv_ff;
         lfw_we = 1'b1; lfw_wa = prv_ff; lfw_wd = nxt_ff;
         lbw_we = 1'b1; lbw_wa = nxt_ff; lbw_wd = prv_ff;
         queued_in[rq_t_ff] = 1'b0;
      end

      if (cmd.tick) begin
         if (count_ff != 16'sh8000) count_in = count_ff - 16'sd1;
         exp_in = (count_in <= 16'sd0);
      end

      if (cmd.rot_rd0) begin
         tlv_re = 1'b1; tlv_ra = owner_ff;
         lfw_re = 1'b1; lfw_ra = owner_ff;
      end
      if (cmd.rot_rd1) begin
         tlv_re = 1'b1; tlv_ra = lfw_rd;
         fol_re = 1'b1; fol_ra = tlv_rd;
      end
      if (cmd.rot_wr) begin
         nol_we = 1'b1;
         nol_wa = lv_ff;
         nol_wd = (tlv_rd == lv_ff) ? nxt_ff : fol_rd;
      end

      if (cmd.own_rd) begin
         tsv_re   = 1'b1;
         owner_in = rq_t_ff;
      end
      if (cmd.own_ld) count_in = tsv_rd;
      if (cmd.sav_rd) tqu_re = 1'b1;
      if (cmd.sav_wr) tsv_we = 1'b1;
      if (cmd.exhaust)   count_in = '0;
      if (cmd.set_ticks) count_in = rq_tk_ff;
      if (cmd.rsp_rd) nol_re = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         queued_ff    <= '0;
         top_ff       <= '0;
         count_ff     <= '0;
         owner_ff     <= '0;
         err_ff       <= 1'b0;
         exp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         queued_ff    <= queued_in;
         top_ff       <= top_in;
         count_ff     <= count_in;
         owner_ff     <= owner_in;
         err_ff       <= err_in;
         exp_ff       <= exp_in;
         rsp_valid_ff <= cmd.rsp_go;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_go) begin
         rsp_data.next_thread      <= occ_ff[top_ff] ? 6'(nol_rd) : 6'd0;
         rsp_data.highest_priority <= 8'(top_ff);
         rsp_data.owner_thread     <= 6'(owner_ff);
         rsp_data.ticks_remaining  <= count_ff;
         rsp_data.expired          <= exp_ff;
         rsp_data.error            <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire
